/* hdl/bprt_pkg.sv */
package bprt_pkg;

	localparam int LIMIT_W = 16;
	localparam int WORK_LIMIT_W = 20;
	localparam int DUTY_W = 7;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_WORK = 2'd1;
	localparam logic [1:0] MODE_PAUSE = 2'd2;
	localparam logic [1:0] MODE_CLOSED = 2'd3;

	localparam logic [1:0] BEEP_NONE = 2'd0;
	localparam logic [1:0] BEEP_WORK = 2'd1;
	localparam logic [1:0] BEEP_FINISH = 2'd2;
	localparam logic [1:0] BEEP_STARTUP = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] REG_SHORT_MIN = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SHORT_MAX = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LONG_HOLD = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_CHARGE_LIMIT = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_WORK_LIMIT = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_DUTY_FIRST = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_DUTY_SECOND = 3'd6;

	localparam logic [LIMIT_W-1:0] SHORT_MIN_RST = 16'd3;
	localparam logic [LIMIT_W-1:0] SHORT_MAX_RST = 16'd1000;
	localparam logic [LIMIT_W-1:0] LONG_HOLD_RST = 16'd2000;
	localparam logic [LIMIT_W-1:0] CHARGE_LIMIT_RST = 16'd200;
	localparam logic [WORK_LIMIT_W-1:0] WORK_LIMIT_RST = 20'd360000;
	localparam logic [DUTY_W-1:0] DUTY_FIRST_RST = 7'd25;
	localparam logic [DUTY_W-1:0] DUTY_SECOND_RST = 7'd66;

	typedef struct packed {
		logic opcode;
		logic first_key_down;
		logic second_key_down;
		logic power_key_down;
		logic charging;
	} tick_t;

	typedef struct packed {
		logic [1:0] run_mode;
		logic power_off;
		logic [1:0] beep_event;
		logic [DUTY_W-1:0] duty;
		logic charge_lock;
	} status_t;

endpackage

/* hdl/button_press_and_run_timer_control.sv */
// Pipeline: an accepted tick is registered in tick_s1 and its result in result_s2 on advance,
// so a stalled output holds the result in result_s2 and, through in_stall, the next tick.
// Throughput: one tick per cycle unless out_stall holds a result; key, charge and work state
// updates in the same cycle that the result register loads, so the next tick sees it at once.
// Reset: arst_n clears all counters, the lock, the mode (idle), power-off and duty, and
// restores the configuration registers to their defaults.
module button_press_and_run_timer_control #(
	parameter int PRESS_COUNT_WIDTH = 16,
	parameter int WORK_COUNT_WIDTH = 20
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input bprt_pkg::tick_t in_data,
	output logic out_valid,
	input logic out_stall,
	output bprt_pkg::status_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [bprt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [bprt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import bprt_pkg::*;

	localparam int PCW = (PRESS_COUNT_WIDTH > LIMIT_W) ? PRESS_COUNT_WIDTH : LIMIT_W;
	localparam int WCW = (WORK_COUNT_WIDTH > WORK_LIMIT_W) ? WORK_COUNT_WIDTH : WORK_LIMIT_W;

	logic [LIMIT_W-1:0] short_min_q, short_max_q, long_hold_q, charge_limit_q;
	logic [WORK_LIMIT_W-1:0] work_limit_q;
	logic [DUTY_W-1:0] duty_first_q, duty_second_q;

	logic [PRESS_COUNT_WIDTH-1:0] first_len_q, second_len_q, power_len_q, charge_len_q;
	logic [PRESS_COUNT_WIDTH-1:0] first_len_d, second_len_d, power_len_d, charge_len_d;
	logic [WORK_COUNT_WIDTH-1:0] work_ticks_q, work_ticks_d;
	logic long_done_q, long_done_d;
	logic lock_q, lock_d;
	logic [1:0] mode_q, mode_d;
	logic power_off_q, power_off_d;
	logic [DUTY_W-1:0] duty_q, duty_d;
	logic [1:0] beep_d;

	tick_t tick_s1;
	logic valid_s1;
	status_t result_s2;
	logic valid_s2;
	logic advance;

	function automatic logic [PRESS_COUNT_WIDTH-1:0] press_inc(
		input logic [PRESS_COUNT_WIDTH-1:0] v
	);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic is_short(
		input logic [PRESS_COUNT_WIDTH-1:0] len,
		input logic [LIMIT_W-1:0] lo,
		input logic [LIMIT_W-1:0] hi
	);
		return (PCW'(len) > PCW'(lo)) && (PCW'(len) < PCW'(hi));
	endfunction

	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign out_valid = valid_s2;
	assign out_data = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_min_q <= SHORT_MIN_RST;
			short_max_q <= SHORT_MAX_RST;
			long_hold_q <= LONG_HOLD_RST;
			charge_limit_q <= CHARGE_LIMIT_RST;
			work_limit_q <= WORK_LIMIT_RST;
			duty_first_q <= DUTY_FIRST_RST;
			duty_second_q <= DUTY_SECOND_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SHORT_MIN: short_min_q <= cfg_wdata[LIMIT_W-1:0];
				REG_SHORT_MAX: short_max_q <= cfg_wdata[LIMIT_W-1:0];
				REG_LONG_HOLD: long_hold_q <= cfg_wdata[LIMIT_W-1:0];
				REG_CHARGE_LIMIT: charge_limit_q <= cfg_wdata[LIMIT_W-1:0];
				REG_WORK_LIMIT: work_limit_q <= cfg_wdata[WORK_LIMIT_W-1:0];
				REG_DUTY_FIRST: duty_first_q <= cfg_wdata[DUTY_W-1:0];
				REG_DUTY_SECOND: duty_second_q <= cfg_wdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		first_len_d = first_len_q;
		second_len_d = second_len_q;
		power_len_d = power_len_q;
		charge_len_d = charge_len_q;
		work_ticks_d = work_ticks_q;
		long_done_d = long_done_q;
		lock_d = lock_q;
		mode_d = mode_q;
		power_off_d = power_off_q;
		duty_d = duty_q;
		beep_d = BEEP_NONE;
		if (!tick_s1.opcode) begin
			if (tick_s1.first_key_down) begin
				first_len_d = press_inc(first_len_q);
			end else begin
				if (is_short(first_len_q, short_min_q, short_max_q)) begin
					beep_d = BEEP_WORK;
					mode_d = MODE_WORK;
					duty_d = duty_first_q;
				end
				first_len_d = '0;
			end
			if (tick_s1.second_key_down) begin
				second_len_d = press_inc(second_len_q);
			end else begin
				if (is_short(second_len_q, short_min_q, short_max_q)) begin
					beep_d = BEEP_WORK;
					mode_d = MODE_WORK;
					duty_d = duty_second_q;
				end
				second_len_d = '0;
			end
			if (tick_s1.power_key_down) begin
				power_len_d = press_inc(power_len_q);
				if ((PCW'(power_len_d) > PCW'(long_hold_q)) && !long_done_q && !lock_q) begin
					power_off_d = !power_off_q;
					beep_d = BEEP_STARTUP;
					long_done_d = 1'b1;
				end
			end else begin
				if (is_short(power_len_q, short_min_q, short_max_q)) begin
					beep_d = BEEP_WORK;
					mode_d = MODE_PAUSE;
				end
				power_len_d = '0;
				long_done_d = 1'b0;
			end
		end else begin
			if (tick_s1.charging) begin
				charge_len_d = press_inc(charge_len_q);
				if (PCW'(charge_len_d) > PCW'(charge_limit_q)) begin
					power_off_d = 1'b1;
					mode_d = MODE_CLOSED;
					lock_d = 1'b1;
				end
			end else begin
				charge_len_d = '0;
			end
			if (mode_d == MODE_WORK) begin
				work_ticks_d = (&work_ticks_q) ? work_ticks_q : work_ticks_q + 1'b1;
				if (WCW'(work_ticks_d) > WCW'(work_limit_q)) begin
					mode_d = MODE_IDLE;
					beep_d = BEEP_FINISH;
				end
			end else if (mode_d != MODE_PAUSE) begin
				work_ticks_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			first_len_q <= '0;
			second_len_q <= '0;
			power_len_q <= '0;
			charge_len_q <= '0;
			work_ticks_q <= '0;
			long_done_q <= 1'b0;
			lock_q <= 1'b0;
			mode_q <= MODE_IDLE;
			power_off_q <= 1'b0;
			duty_q <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (!valid_s2 || !out_stall) begin
				valid_s2 <= valid_s1;
			end
			if (advance) begin
				first_len_q <= first_len_d;
				second_len_q <= second_len_d;
				power_len_q <= power_len_d;
				charge_len_q <= charge_len_d;
				work_ticks_q <= work_ticks_d;
				long_done_q <= long_done_d;
				lock_q <= lock_d;
				mode_q <= mode_d;
				power_off_q <= power_off_d;
				duty_q <= duty_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			tick_s1 <= in_data;
		end
		if (advance) begin
			result_s2.run_mode <= mode_d;
			result_s2.power_off <= power_off_d;
			result_s2.beep_event <= beep_d;
			result_s2.duty <= duty_d;
			result_s2.charge_lock <= lock_d;
		end
	end

endmodule

/* hdl/bprt_checker.sv */
module bprt_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input bprt_pkg::status_t out_data
);
	import bprt_pkg::*;

	logic lock_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_seen_q <= 1'b0;
		end else if (out_valid && !out_stall && out_data.charge_lock) begin
			lock_seen_q <= 1'b1;
		end
	end

	// Once a transfer has shown the charge lock, every later result keeps it.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lock_seen_q |-> out_data.charge_lock)
		else $error("charge lock dropped after it was set");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.beep_event == BEEP_FINISH |-> out_data.run_mode == MODE_IDLE)
		else $error("finish beep without idle mode");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.charge_lock |-> out_data.beep_event != BEEP_STARTUP)
		else $error("power toggle while charge lock is set");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.beep_event == BEEP_WORK
		|-> out_data.run_mode == MODE_WORK || out_data.run_mode == MODE_PAUSE)
		else $error("work beep without work or pause mode");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

bind button_press_and_run_timer_control bprt_checker u_bprt_checker (.*);
